// File: sv/assert_macros.svh
// assertion macros used by the top-level module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication on the same edge
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication onto the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tcp_pkg.sv
// shared widths, latencies and register map of the cull and project block
package tcp_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned NUM_W = COORD_W + SCALE_W;
  localparam int unsigned DIV_W = COORD_W;
  localparam int unsigned CLAMP_W = 47;
  localparam int unsigned LANE_LAT = NUM_W + 4;
  localparam int unsigned CULL_LAT = 6;
  localparam int unsigned N_VERT = 3;
  localparam int unsigned N_LANE = 6;
  localparam int unsigned IN_W = 9 * COORD_W;
  localparam int unsigned OUT_W = N_LANE * COORD_W;
  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_X_SCALE  = 3'd0,
    REG_Y_SCALE  = 3'd1,
    REG_SCR_W    = 3'd2,
    REG_SCR_H    = 3'd3,
    REG_CAM_X    = 3'd4,
    REG_CAM_Y    = 3'd5,
    REG_CAM_Z    = 3'd6,
    REG_RESERVED = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [SIZE_W-1:0]  scr_w;
    logic [SIZE_W-1:0]  scr_h;
    logic [2:0][COORD_W-1:0] cam;
  } cfg_t;

endpackage

// File: sv/tcp_lane.sv
// one projection lane: scale multiply, pipelined divide, offset and screen scale
module tcp_lane import tcp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] coord_i,
  input  logic signed [COORD_W-1:0] depth_i,
  input  logic [SCALE_W-1:0]        scale_i,
  input  logic [SIZE_W-1:0]         size_i,
  output logic signed [COORD_W-1:0] pix_o
);

  localparam logic [DIV_W-1:0] ZERO_DIV = DIV_W'(64'd1 << FRAC_BITS);
  localparam logic signed [CLAMP_W-1:0] LIM_POS = CLAMP_W'(64'sd1 <<< 45);
  localparam logic signed [CLAMP_W-1:0] LIM_NEG = -LIM_POS;

  logic signed [NUM_W:0]      num_q;
  logic signed [COORD_W-1:0]  z_q;
  logic [SIZE_W-1:0]          size0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= coord_i * $signed({1'b0, scale_i});
      z_q     <= depth_i;
      size0_q <= size_i;
    end
  end

  logic             ent_neg;
  logic [NUM_W-1:0] ent_num;
  logic [DIV_W-1:0] ent_div;
  logic [NUM_W:0]   num_neg;
  logic [COORD_W-1:0] z_neg;

  always_comb begin
    num_neg = -num_q;
    z_neg   = -z_q;
    ent_neg = num_q[NUM_W] ^ ((z_q != '0) && z_q[COORD_W-1]);
    ent_num = num_q[NUM_W] ? num_neg[NUM_W-1:0] : num_q[NUM_W-1:0];
    if (z_q == '0) begin
      ent_div = ZERO_DIV;
    end else begin
      ent_div = z_q[COORD_W-1] ? z_neg : z_q;
    end
  end

  logic [DIV_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  nm_q   [NUM_W];
  logic [NUM_W-1:0]  quo_q  [NUM_W];
  logic [DIV_W-1:0]  div_q  [NUM_W];
  logic              neg_q  [NUM_W];
  logic [SIZE_W-1:0] size_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [DIV_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nm_in;
    logic [NUM_W-1:0]  quo_in;
    logic [DIV_W-1:0]  div_in;
    logic              neg_in;
    logic [SIZE_W-1:0] size_in;
    logic [DIV_W:0]    trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nm_in   = ent_num;
      assign quo_in  = '0;
      assign div_in  = ent_div;
      assign neg_in  = ent_neg;
      assign size_in = size0_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign nm_in   = nm_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign div_in  = div_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign size_in = size_q[k-1];
    end

    assign trial = {rem_in, nm_in[NUM_W-1]};
    assign fits  = trial >= {1'b0, div_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? DIV_W'(trial - {1'b0, div_in}) : trial[DIV_W-1:0];
        nm_q[k]   <= {nm_in[NUM_W-2:0], 1'b0};
        quo_q[k]  <= {quo_in[NUM_W-2:0], fits};
        div_q[k]  <= div_in;
        neg_q[k]  <= neg_in;
        size_q[k] <= size_in;
      end
    end
  end

  logic signed [NUM_W+1:0]   q_s;
  logic signed [NUM_W+1:0]   t_s;
  logic signed [CLAMP_W-1:0] t_q;
  logic [SIZE_W-1:0]         size_t_q;
  logic signed [CLAMP_W+SIZE_W:0] prod_q;
  logic signed [CLAMP_W+SIZE_W:0] half_s;

  always_comb begin
    q_s = neg_q[NUM_W-1] ? -$signed({2'b00, quo_q[NUM_W-1]})
                         : $signed({2'b00, quo_q[NUM_W-1]});
    t_s = q_s + $signed((NUM_W+2)'(64'd1 << FRAC_BITS));
    half_s = (prod_q + $signed({{(CLAMP_W+SIZE_W){1'b0}}, prod_q[CLAMP_W+SIZE_W]})) >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (t_s > (NUM_W+2)'(LIM_POS)) begin
        t_q <= LIM_POS;
      end else if (t_s < (NUM_W+2)'(LIM_NEG)) begin
        t_q <= LIM_NEG;
      end else begin
        t_q <= t_s[CLAMP_W-1:0];
      end
      size_t_q <= size_q[NUM_W-1];
      prod_q   <= t_q * $signed({1'b0, size_t_q});
      if (half_s > (CLAMP_W+SIZE_W+1)'(64'sd2147483647)) begin
        pix_o <= 32'sh7fffffff;
      end else if (half_s < -(CLAMP_W+SIZE_W+1)'(64'sd2147483648)) begin
        pix_o <= 32'sh80000000;
      end else begin
        pix_o <= half_s[COORD_W-1:0];
      end
    end
  end

endmodule

// File: sv/tcp_cull.sv
// back-face test: exact normal dot view vector, delayed to the lane latency
module tcp_cull import tcp_pkg::*; #(
  parameter int unsigned DELAY = LANE_LAT - CULL_LAT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic [N_VERT-1:0][2:0][COORD_W-1:0]  vert_i,
  input  logic [2:0][COORD_W-1:0]              cam_i,
  output logic                                 keep_o
);

  logic signed [COORD_W:0]     a_q [3];
  logic signed [COORD_W:0]     b_q [3];
  logic signed [COORD_W:0]     l1_q [3];
  logic signed [COORD_W:0]     l2_q [3];
  logic signed [COORD_W:0]     l3_q [3];
  logic signed [2*COORD_W+1:0] m1_q [3];
  logic signed [2*COORD_W+1:0] m2_q [3];
  logic signed [2*COORD_W+2:0] n_q [3];
  logic signed [2*COORD_W+1:0] ph_q [3];
  logic signed [2*COORD_W+3:0] pl_q [3];
  logic signed [2*COORD_W+3:0] sh_q;
  logic signed [2*COORD_W+5:0] sl_q;
  logic signed [3*COORD_W+5:0] dot_s;
  logic                        cull_q;
  logic [DELAY-1:0]            dly_q;

  assign dot_s = ($signed({{(COORD_W-2){sh_q[2*COORD_W+3]}}, sh_q}) <<< 34)
               + $signed({{(COORD_W){sl_q[2*COORD_W+5]}}, sl_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k]  <= $signed(vert_i[1][k]) - $signed(vert_i[0][k]);
        b_q[k]  <= $signed(vert_i[2][k]) - $signed(vert_i[0][k]);
        l1_q[k] <= $signed(vert_i[0][k]) - $signed(cam_i[k]);
        l2_q[k] <= l1_q[k];
        l3_q[k] <= l2_q[k];
        n_q[k]  <= m1_q[k] - m2_q[k];
        ph_q[k] <= $signed(n_q[k][2*COORD_W+2:34]) * l3_q[k];
        pl_q[k] <= $signed({1'b0, n_q[k][33:0]}) * l3_q[k];
      end
      m1_q[0] <= a_q[1] * b_q[2];
      m2_q[0] <= a_q[2] * b_q[1];
      m1_q[1] <= a_q[2] * b_q[0];
      m2_q[1] <= a_q[0] * b_q[2];
      m1_q[2] <= a_q[0] * b_q[1];
      m2_q[2] <= a_q[1] * b_q[0];
      sh_q <= ph_q[0] + ph_q[1] + ph_q[2];
      sl_q <= pl_q[0] + pl_q[1] + pl_q[2];
      cull_q <= !dot_s[3*COORD_W+5] && (dot_s != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q <= '0;
    end else if (en_i) begin
      dly_q <= {dly_q[DELAY-2:0], !cull_q};
    end
  end

  assign keep_o = dly_q[DELAY-1];

endmodule

// File: sv/triangle_cull_and_project.sv
// top level: register port, six projection lanes, cull test and result merge
//
// Triangles enter on s_axis (nine signed 32-bit coordinates, v0_x first in
// the low bits). Each triangle runs through six projection lanes (x and y of
// each vertex) and the back-face test side by side; the merge stage drops
// culled triangles and loads surviving ones into the m_axis output register.
// The path from input transfer to m_axis_tvalid runs through the 56-stage
// pipelined divider in each lane plus the scale and screen stages.
// Throughput is one triangle per cycle while the output is not stalled.
// When m_axis_tready is low with a result waiting, the whole pipeline halts
// and s_axis_tready drops; nothing is lost or repeated.
// Reset clears all valid flags and loads the register defaults (scale 1.0,
// 640 x 480 screen, camera at the origin). The user must write registers
// over the APB-style port at byte addresses 0, 4, ... 24 only while no
// triangle is in flight (not enforced by the block). pready is always high.
module triangle_cull_and_project import tcp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // p0_x p0_y p1_x p1_y p2_x p2_y
  output logic [OUT_W-1:0]  m_axis_tdata
);

  `include "assert_macros.svh"

  cfg_t     cfg_q;
  reg_idx_e widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_scale <= SCALE_W'(64'd1 << FRAC_BITS);
      cfg_q.y_scale <= SCALE_W'(64'd1 << FRAC_BITS);
      cfg_q.scr_w   <= SIZE_W'(640);
      cfg_q.scr_h   <= SIZE_W'(480);
      cfg_q.cam     <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_X_SCALE: cfg_q.x_scale <= pwdata[SCALE_W-1:0];
        REG_Y_SCALE: cfg_q.y_scale <= pwdata[SCALE_W-1:0];
        REG_SCR_W:   cfg_q.scr_w   <= pwdata[SIZE_W-1:0];
        REG_SCR_H:   cfg_q.scr_h   <= pwdata[SIZE_W-1:0];
        REG_CAM_X:   cfg_q.cam[0]  <= pwdata;
        REG_CAM_Y:   cfg_q.cam[1]  <= pwdata;
        REG_CAM_Z:   cfg_q.cam[2]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_X_SCALE: prdata = {{(32-SCALE_W){1'b0}}, cfg_q.x_scale};
      REG_Y_SCALE: prdata = {{(32-SCALE_W){1'b0}}, cfg_q.y_scale};
      REG_SCR_W:   prdata = {{(32-SIZE_W){1'b0}}, cfg_q.scr_w};
      REG_SCR_H:   prdata = {{(32-SIZE_W){1'b0}}, cfg_q.scr_h};
      REG_CAM_X:   prdata = cfg_q.cam[0];
      REG_CAM_Y:   prdata = cfg_q.cam[1];
      REG_CAM_Z:   prdata = cfg_q.cam[2];
      default:     prdata = '0;
    endcase
  end

  logic en;
  logic [N_VERT-1:0][2:0][COORD_W-1:0] vert;
  logic [N_LANE-1:0][COORD_W-1:0] pix;
  logic keep;
  logic [LANE_LAT-1:0] vld_q;
  logic                out_vld_q;
  logic [OUT_W-1:0]    out_data_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign vert          = s_axis_tdata;

  for (genvar i = 0; i < N_VERT; i++) begin : g_vert
    tcp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clk_i   (clk_i),
      .en_i    (en),
      .coord_i (vert[i][0]),
      .depth_i (vert[i][2]),
      .scale_i (cfg_q.x_scale),
      .size_i  (cfg_q.scr_w),
      .pix_o   (pix[2*i])
    );
    tcp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clk_i   (clk_i),
      .en_i    (en),
      .coord_i (vert[i][1]),
      .depth_i (vert[i][2]),
      .scale_i (cfg_q.y_scale),
      .size_i  (cfg_q.scr_h),
      .pix_o   (pix[2*i+1])
    );
  end

  tcp_cull #(.DELAY(LANE_LAT - CULL_LAT)) u_cull (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vert_i (vert),
    .cam_i  (cfg_q.cam),
    .keep_o (keep)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LANE_LAT-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[LANE_LAT-1] && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= pix;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_NEXT(a_take_enters, s_axis_tvalid && s_axis_tready, vld_q[0], "transfer lost at entry")
  `ASSERT_IMPLIES(a_out_source, $rose(out_vld_q), $past(vld_q[LANE_LAT-1]), "result without item")
  `ASSERT_NEXT(a_stall_holds, !en, $stable(vld_q), "pipeline moved while stalled")

endmodule
